/* hdl/acpc_pkg.sv */
package acpc_pkg;

   // default sizes of the profile store
   localparam int MAX_COLUMNS_DEF = 4096;
   localparam int COUNT_BITS_DEF  = 32;
   localparam int WEIGHT_BITS_DEF = 16;

   // bins per column
   localparam int NUM_BINS = 29;

   // bin codes
   localparam logic [4:0] BIN_QMARK = 5'd26;
   localparam logic [4:0] BIN_PUNCT = 5'd27;
   localparam logic [4:0] BIN_OTHER = 5'd28;
   localparam logic [4:0] LAST_BIN  = BIN_OTHER;

   // character codes
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_QMARK   = 8'h3F;

   // reset value of the columns in use register
   localparam logic [12:0] COLUMNS_RESET = 13'd4096;

   // transaction operation codes
   typedef enum logic [1:0] {
      OP_ACCUMULATE,
      OP_READ,
      OP_READ_CLEAR
   } op_type;

   // control sequencer
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_ISSUE,
      ST_RD_WAIT
   } state_type;

   // map a character byte onto its bin
   function automatic logic [4:0] classify_symbol(input logic [7:0] c);
      logic [4:0] bin;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         bin = 5'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         bin = 5'(c - CHAR_LOWER_A);
      end else if (c == CHAR_QMARK) begin
         bin = BIN_QMARK;
      end else if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                   (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126)) begin
         // printable punctuation outside letters and digits
         bin = BIN_PUNCT;
      end else begin
         bin = BIN_OTHER;
      end
      return bin;
   endfunction

endpackage

/* hdl/alignment_column_profile_counter.sv */
// Weighted composition profile of a sequence alignment, one row of bins per column.
// Request channel (req_*): operation, column, symbol, weight; valid/ready handshake.
//   Accumulate adds the weight to the column's bin for the symbol class, saturating.
//   Read returns the column's 29 bins in order; read-and-clear also zeroes them.
// Response channel (rsp_*): category, count, last, range_error; valid/ready handshake.
// Accumulates are taken one per cycle while idle: a read-modify-write pipeline on
// the single count memory, with forwarding of the previous cycle's write.
// A read handles each bin in order with a memory read (ST_RD_ISSUE), then a load of
// the response register (ST_RD_WAIT).
// A rejected column gives one error transaction in the cycle after acceptance.
// Operation code 3 is accepted and dropped.
// After reset the memory is swept to zero, one entry per cycle, over all
// MAX_COLUMNS * 29 entries (118784 at the default size); req_ready is low meanwhile.
// csr_wdata is written on csr_wen at any time and takes effect on the next transaction.
// A stalled response holds in its register; readouts pause until it is taken and
// requests are still taken unless they need the response register at once.
module alignment_column_profile_counter #(
   parameter int MAX_COLUMNS = acpc_pkg::MAX_COLUMNS_DEF,
   parameter int COUNT_BITS  = acpc_pkg::COUNT_BITS_DEF,
   parameter int WEIGHT_BITS = acpc_pkg::WEIGHT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [11:0] req_column,
   input  logic [7:0]  req_symbol,
   input  logic [15:0] req_weight,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_category,
   output logic [31:0] rsp_count,
   output logic        rsp_last,
   output logic        rsp_range_error,
   input  logic        csr_wen,
   input  logic [12:0] csr_wdata
);

   localparam int DEPTH     = MAX_COLUMNS * acpc_pkg::NUM_BINS;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_BITS  = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
   localparam logic [15:0] WEIGHT_MASK =
      (WEIGHT_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << WEIGHT_BITS) - 32'd1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // count memory
   logic [COUNT_BITS-1:0] mem [DEPTH];
   logic [COUNT_BITS-1:0] rdata_ff;
   logic [ADDR_BITS-1:0]  mem_raddr;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_waddr;
   logic [COUNT_BITS-1:0] mem_wdata;

   // control state
   acpc_pkg::state_type   state_ff, state_in;
   logic [ADDR_BITS-1:0]  sweep_ff, sweep_in;
   logic [12:0]           limit_ff, limit_in;
   logic                  acc_valid_ff, acc_valid_in;
   logic [ADDR_BITS-1:0]  acc_addr_ff, acc_addr_in;
   logic [15:0]           acc_weight_ff, acc_weight_in;
   logic [ADDR_BITS-1:0]  rd_base_ff, rd_base_in;
   logic                  rd_clear_ff, rd_clear_in;
   logic [4:0]            bin_ff, bin_in;
   logic                  wb_valid_ff;
   logic [ADDR_BITS-1:0]  wb_addr_ff;
   logic [COUNT_BITS-1:0] wb_data_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [4:0]            category_ff, category_in;
   logic [31:0]           count_ff, count_in;
   logic                  last_ff, last_in;
   logic                  error_ff, error_in;

   // request decode
   acpc_pkg::op_type      req_op;
   logic                  op_known;
   logic                  out_of_range;
   logic                  needs_rsp;
   logic                  out_free;
   logic                  accept;
   logic [ADDR_BITS-1:0]  col_base;
   logic [ADDR_BITS-1:0]  rd_addr;

   // forwarding and saturating add
   logic [ADDR_BITS-1:0]  use_addr;
   logic [COUNT_BITS-1:0] cur_count;
   logic [SUM_BITS-1:0]   sum;
   logic [COUNT_BITS-1:0] acc_result;
   logic [63:0]           cur_wide;

   // memory ports, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // request decode
   assign req_op       = acpc_pkg::op_type'(req_operation);
   assign op_known     = (req_op == acpc_pkg::OP_ACCUMULATE) ||
                         (req_op == acpc_pkg::OP_READ) ||
                         (req_op == acpc_pkg::OP_READ_CLEAR);
   assign out_of_range = ({1'b0, req_column} >= limit_ff) ||
                         (32'(req_column) >= MAX_COLUMNS);
   assign needs_rsp    = op_known && out_of_range;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == acpc_pkg::ST_IDLE) && (out_free || !needs_rsp);
   assign accept       = req_valid && req_ready;
   assign col_base     = ADDR_BITS'(32'(req_column) * acpc_pkg::NUM_BINS);
   assign rd_addr      = rd_base_ff + ADDR_BITS'(bin_ff);

   // read data with the previous cycle's write forwarded
   assign use_addr   = acc_valid_ff ? acc_addr_ff : rd_addr;
   assign cur_count  = (wb_valid_ff && (wb_addr_ff == use_addr)) ? wb_data_ff : rdata_ff;
   assign sum        = SUM_BITS'(cur_count) + SUM_BITS'(acc_weight_ff);
   assign acc_result = (sum > SUM_BITS'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(sum);
   assign cur_wide   = 64'(cur_count);

   // sequencer, memory control and response loading
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      limit_in      = csr_wen ? csr_wdata : limit_ff;
      acc_valid_in  = 1'b0;
      acc_addr_in   = acc_addr_ff;
      acc_weight_in = acc_weight_ff;
      rd_base_in    = rd_base_ff;
      rd_clear_in   = rd_clear_ff;
      bin_in        = bin_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      category_in   = category_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      error_in      = error_ff;
      mem_raddr     = rd_addr;
      mem_we        = 1'b0;
      mem_waddr     = acc_addr_ff;
      mem_wdata     = acc_result;

      // write back of the accumulate from the previous cycle
      if (acc_valid_ff) begin
         mem_we = 1'b1;
      end

      case (state_ff)
         acpc_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            sweep_in  = sweep_ff + ADDR_BITS'(1);
            if (32'(sweep_ff) == DEPTH - 1) begin
               state_in = acpc_pkg::ST_IDLE;
            end
         end
         acpc_pkg::ST_IDLE: begin
            mem_raddr = col_base + ADDR_BITS'(acpc_pkg::classify_symbol(req_symbol));
            if (accept && op_known) begin
               if (out_of_range) begin
                  rsp_valid_in = 1'b1;
                  category_in  = '0;
                  count_in     = '0;
                  last_in      = 1'b1;
                  error_in     = 1'b1;
               end else if (req_op == acpc_pkg::OP_ACCUMULATE) begin
                  acc_valid_in  = 1'b1;
                  acc_addr_in   = mem_raddr;
                  acc_weight_in = req_weight & WEIGHT_MASK;
               end else begin
                  rd_base_in  = col_base;
                  rd_clear_in = (req_op == acpc_pkg::OP_READ_CLEAR);
                  bin_in      = '0;
                  state_in    = acpc_pkg::ST_RD_ISSUE;
               end
            end
         end
         acpc_pkg::ST_RD_ISSUE: begin
            // read the bin once the response register will be free
            if (out_free) begin
               state_in = acpc_pkg::ST_RD_WAIT;
            end
         end
         acpc_pkg::ST_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            category_in  = bin_ff;
            count_in     = cur_wide[31:0];
            last_in      = (bin_ff == acpc_pkg::LAST_BIN);
            error_in     = 1'b0;
            if (rd_clear_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_addr;
               mem_wdata = '0;
            end
            if (bin_ff == acpc_pkg::LAST_BIN) begin
               state_in = acpc_pkg::ST_IDLE;
            end else begin
               bin_in   = bin_ff + 5'd1;
               state_in = acpc_pkg::ST_RD_ISSUE;
            end
         end
         default: begin
            state_in = acpc_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acpc_pkg::ST_CLEAR;
         sweep_ff     <= '0;
         limit_ff     <= acpc_pkg::COLUMNS_RESET;
         acc_valid_ff <= 1'b0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         limit_ff     <= limit_in;
         acc_valid_ff <= acc_valid_in;
         wb_valid_ff  <= mem_we;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_addr_ff   <= acc_addr_in;
      acc_weight_ff <= acc_weight_in;
      rd_base_ff    <= rd_base_in;
      rd_clear_ff   <= rd_clear_in;
      bin_ff        <= bin_in;
      wb_addr_ff    <= mem_waddr;
      wb_data_ff    <= mem_wdata;
      category_ff   <= category_in;
      count_ff      <= count_in;
      last_ff       <= last_in;
      error_ff      <= error_in;
   end

   // response ports
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_category    = category_ff;
   assign rsp_count       = count_ff;
   assign rsp_last        = last_ff;
   assign rsp_range_error = error_ff;

endmodule
